// ===== hw/rtl/wsc_pkg.sv =====
package wsc_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LEN_FIELD_W     = 32;
    localparam int HDR_IDX_W       = 4;

    localparam logic [7:0]             HDR_FIRST    = 8'h82;
    localparam logic [7:0]             LEN16_CODE   = 8'hFE;
    localparam logic [7:0]             LEN64_CODE   = 8'hFF;
    localparam logic [LEN_FIELD_W-1:0] SHORT_MAX    = 32'd125;
    localparam logic [LEN_FIELD_W-1:0] MEDIUM_LIMIT = 32'd65536;

    localparam logic [HDR_IDX_W-1:0] HDR_N_SHORT  = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_N_MEDIUM = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_N_LONG   = 4'd14;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_HDR  = 1'b0,
        KIND_BYTE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CLS_SHORT  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LONG   = 2'd2
    } t_len_class;

    typedef struct packed {
        t_kind                  kind;
        t_len_class             cls;
        logic [LEN_FIELD_W-1:0] len;
        logic [31:0]            key;
        logic [7:0]             data;
        logic                   done;
        logic                   err;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [HDR_IDX_W-1:0] hdr_count(t_len_class cls);
        logic [HDR_IDX_W-1:0] n;
        unique case (cls)
            CLS_SHORT:  n = HDR_N_SHORT;
            CLS_MEDIUM: n = HDR_N_MEDIUM;
            default:    n = HDR_N_LONG;
        endcase
        return n;
    endfunction

    // byte idx of the header: first byte, length code, extended length, mask key
    function automatic logic [7:0] hdr_byte(t_len_class cls, logic [HDR_IDX_W-1:0] idx,
                                            logic [LEN_FIELD_W-1:0] len, logic [31:0] key);
        logic [7:0]           b;
        logic [HDR_IDX_W-1:0] kb;
        logic [1:0]           k;
        logic [1:0]           j;
        unique case (cls)
            CLS_SHORT:  kb = 4'd2;
            CLS_MEDIUM: kb = 4'd4;
            default:    kb = 4'd10;
        endcase
        k = 2'(idx - kb);
        j = 2'(idx - 4'd6);
        b = '0;
        if (idx == '0) begin
            b = HDR_FIRST;
        end else if (idx >= kb) begin
            b = key[{~k, 3'b000} +: 8];
        end else begin
            unique case (cls)
                CLS_SHORT: begin
                    b = {1'b1, len[6:0]};
                end
                CLS_MEDIUM: begin
                    if (idx == 4'd1) b = LEN16_CODE;
                    else if (idx == 4'd2) b = len[15:8];
                    else b = len[7:0];
                end
                default: begin
                    // upper four bytes of the 64-bit length are always zero
                    if (idx == 4'd1) b = LEN64_CODE;
                    else if (idx >= 4'd6) b = len[{~j, 3'b000} +: 8];
                    else b = '0;
                end
            endcase
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/wsc_front.sv =====
module wsc_front #(
    parameter int LENGTH_BITS = wsc_pkg::LENGTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [wsc_pkg::LEN_FIELD_W-1:0]     i_frame_length,
    input  logic [31:0]                         i_mask_key,
    input  logic [7:0]                          i_payload_byte,
    input  wsc_pkg::t_q_status                  i_q_status,
    output logic                                o_push,
    output wsc_pkg::t_job                       o_job
);

    localparam int LEN_W = (LENGTH_BITS < wsc_pkg::LEN_FIELD_W) ? LENGTH_BITS
                                                               : wsc_pkg::LEN_FIELD_W;

    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]       r_mask_pos, n_mask_pos;
    logic [31:0]      r_mask_reg, n_mask_reg;
    logic             r_open, n_open;

    logic                              accept;
    logic [LEN_W-1:0]                  len_lim;
    logic [wsc_pkg::LEN_FIELD_W-1:0]   len_ext;
    logic [LEN_W-1:0]                  left_dec;
    logic [7:0]                        mask_byte;

    assign accept    = i_valid && !i_q_status.full;
    assign o_stall   = i_q_status.full;
    assign o_push    = accept;
    assign len_lim   = i_frame_length[LEN_W-1:0];
    assign len_ext   = wsc_pkg::LEN_FIELD_W'(len_lim);
    assign left_dec  = r_bytes_left - 1'b1;
    assign mask_byte = r_mask_reg[{~r_mask_pos, 3'b000} +: 8];

    always_comb begin
        o_job        = '0;
        n_bytes_left = r_bytes_left;
        n_mask_pos   = r_mask_pos;
        n_mask_reg   = r_mask_reg;
        n_open       = r_open;
        if (i_cmd == wsc_pkg::CMD_START) begin
            o_job.kind = wsc_pkg::KIND_HDR;
            if (len_ext <= wsc_pkg::SHORT_MAX) o_job.cls = wsc_pkg::CLS_SHORT;
            else if (len_ext < wsc_pkg::MEDIUM_LIMIT) o_job.cls = wsc_pkg::CLS_MEDIUM;
            else o_job.cls = wsc_pkg::CLS_LONG;
            o_job.len = len_ext;
            o_job.key = i_mask_key;
            if (accept) begin
                n_mask_reg   = i_mask_key;
                n_mask_pos   = '0;
                n_bytes_left = len_lim;
                n_open       = (len_lim != '0);
            end
        end else if (!r_open) begin
            // data with no frame open: lone error result, state untouched
            o_job.kind = wsc_pkg::KIND_BYTE;
            o_job.err  = 1'b1;
        end else begin
            o_job.kind = wsc_pkg::KIND_BYTE;
            o_job.data = i_payload_byte ^ mask_byte;
            o_job.done = (left_dec == '0);
            if (accept) begin
                n_mask_pos   = r_mask_pos + 1'b1;
                n_bytes_left = left_dec;
                n_open       = (left_dec != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_mask_pos   <= '0;
            r_mask_reg   <= '0;
            r_open       <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_mask_pos   <= n_mask_pos;
            r_mask_reg   <= n_mask_reg;
            r_open       <= n_open;
        end
    end

endmodule

// ===== hw/rtl/wsc_queue.sv =====
module wsc_queue #(
    parameter int DEPTH = wsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsc_pkg::t_job      i_job,
    input  logic               i_pop,
    output wsc_pkg::t_job      o_head,
    output wsc_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsc_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

// ===== hw/rtl/wsc_back.sv =====
module wsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsc_pkg::t_job      i_head,
    input  wsc_pkg::t_q_status i_q_status,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_frame_done,
    output logic               o_error_flag
);

    logic [wsc_pkg::HDR_IDX_W-1:0] r_idx, n_idx;
    logic                          r_valid, n_valid;
    logic [7:0]                    r_byte;
    logic                          r_last, r_done, r_err;

    logic                          can_load;
    logic                          emit;
    logic                          hdr_last;
    logic [7:0]                    e_byte;
    logic                          e_last, e_done, e_err;

    assign can_load = !r_valid || !i_stall;
    assign emit     = can_load && !i_q_status.empty;
    assign hdr_last = (r_idx == wsc_pkg::hdr_count(i_head.cls) - 1'b1);

    always_comb begin
        if (i_head.kind == wsc_pkg::KIND_BYTE) begin
            e_byte = i_head.data;
            e_last = 1'b1;
            e_done = i_head.done;
            e_err  = i_head.err;
        end else begin
            e_byte = wsc_pkg::hdr_byte(i_head.cls, r_idx, i_head.len, i_head.key);
            e_last = hdr_last;
            e_done = hdr_last && (i_head.len == '0);
            e_err  = 1'b0;
        end
    end

    always_comb begin
        o_pop = emit && ((i_head.kind == wsc_pkg::KIND_BYTE) || hdr_last);
        n_idx = r_idx;
        if (emit && (i_head.kind == wsc_pkg::KIND_HDR)) begin
            n_idx = hdr_last ? '0 : r_idx + 1'b1;
        end
        if (emit) n_valid = 1'b1;
        else if (can_load) n_valid = 1'b0;
        else n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= e_byte;
            r_last <= e_last;
            r_done <= e_done;
            r_err  <= e_err;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_last;
    assign o_frame_done = r_done;
    assign o_error_flag = r_err;

endmodule

// ===== hw/rtl/websocket_client_frame_tx.sv =====
// Client-to-server WebSocket binary frame builder with payload masking. A start
// item (cmd 0) opens a frame and yields its header: 0x82, the length byte with the
// mask bit set (plus 2 or 8 extended length bytes) and the four mask key bytes,
// 6, 8 or 14 output bytes in all. Each data item (cmd 1) yields one masked payload
// byte, or a single error result when no frame is open. The front end takes one
// item per cycle whenever its job queue (QUEUE_DEPTH entries) has room and updates
// the frame state at once; the back end sends one byte per cycle from the queue
// head into the output register while the output is not stalled, so data items
// flow at one per cycle and a start item holds the output side for its 6, 8 or 14
// header bytes as later items queue. Each item goes via its queue entry to o_valid.
module websocket_client_frame_tx #(
    parameter int LENGTH_BITS = wsc_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = wsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [wsc_pkg::LEN_FIELD_W-1:0] i_frame_length,
    input  logic [31:0]                     i_mask_key,
    input  logic [7:0]                      i_payload_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_run_last,
    output logic                            o_frame_done,
    output logic                            o_error_flag
);

    wsc_pkg::t_q_status q_status;
    wsc_pkg::t_job      push_job;
    wsc_pkg::t_job      head_job;
    logic               push;
    logic               pop;

    wsc_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_frame_length (i_frame_length),
        .i_mask_key     (i_mask_key),
        .i_payload_byte (i_payload_byte),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_job          (push_job)
    );

    wsc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    wsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .o_error_flag (o_error_flag)
    );

    // a queue entry is only popped when one is there
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty job queue");

    // error results carry no frame completion and a zero byte
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_flag) |-> (!o_frame_done && o_run_last && o_out_byte == 8'h00))
        else $error("malformed error result");

    // the byte that closes a frame always closes its item's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_run_last)
        else $error("frame done without run last");

endmodule
